>>> hdl/assert_macros.svh
// Assertion macros shared by the polygon clip RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define PHC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define PHC_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> hdl/phc_pkg.sv
// Types, constants and helpers for the polygon half-plane clip unit
package phc_pkg;

	localparam int COORD_W = 24;
	localparam int DIR_W   = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MULA_W  = DIR_W + 1;
	localparam int SIDE_W  = MULA_W + DIFF_W;
	localparam int FRAC_W  = 16;
	localparam int MAG_W   = SIDE_W;
	localparam int DEN_W   = MAG_W + 1;
	localparam int REM_W   = DEN_W + 1;
	localparam int CFG_W   = COORD_W;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIR_W-1:0]   dir_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [MULA_W-1:0]  mula_t;
	typedef logic signed [SIDE_W-1:0]  side_t;
	typedef logic [FRAC_W-1:0]         frac_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [DEN_W-1:0]          den_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_X = 2'd0,
		REG_BASE_Y = 2'd1,
		REG_DIR_X  = 2'd2,
		REG_DIR_Y  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	localparam frac_t FRAC_MAX = '1;

	function automatic diff_t sx_diff(input coord_t a, input coord_t b);
		sx_diff = diff_t'(a) - diff_t'(b);
	endfunction

	function automatic mag_t abs_side(input side_t v);
		abs_side = v[SIDE_W-1] ? mag_t'(~v + side_t'(1)) : mag_t'(v);
	endfunction

endpackage

>>> hdl/polygon_halfplane_clip_unit.sv
// Top level of the polygon half-plane clip unit (single-edge polygon clip)
//
// Clips a polygon against the half-plane left of the line through
// (base_x, base_y) along (dir_x, dir_y); registers are to be written on the
// cfg port only while the unit is idle, which the unit does not enforce.
// Vertices come in one per transaction; the polygon's last vertex goes first
// with prime set, which only records the start of the closing edge. Each
// vertex gives zero, one or two output transactions: a crossing point
// (is_crossing=1) when the vertex is on the other side from the previous one,
// then the vertex itself if it is inside (side value >= 0). last_of_run marks
// the final output of a vertex. Throughput: one vertex at a time;
// vertex_stall is high from acceptance until the last output transaction of
// that vertex has been taken, or until classify for a vertex with no output.
// A vertex goes through two multiplier passes for the side value, then the
// classify step, which shows a kept vertex with no crossing or returns the
// unit to idle. A vertex with a crossing then goes to the serial divider,
// which forms the 16-bit crossing fraction one bit per cycle, and then to the
// two interpolations; the side value and both interpolations reuse a single
// 17x25 multiplier, one product per cycle. A kept vertex after a crossing
// follows in the cycle after the crossing point is taken, and the next vertex
// can be taken in the cycle after the last output goes. Output stalls hold the unit waiting.
`include "assert_macros.svh"
module polygon_halfplane_clip_unit (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_write_en,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	// vertex channel
	input  logic                vertex_valid,
	output logic                vertex_stall,
	input  phc_pkg::coord_t     vertex_x,
	input  phc_pkg::coord_t     vertex_y,
	input  logic                prime,
	// output point channel
	output logic                point_valid,
	input  logic                point_stall,
	output phc_pkg::coord_t     point_x,
	output phc_pkg::coord_t     point_y,
	output logic                is_crossing,
	output logic                last_of_run
);
	import phc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M0,      // dir_x * (y - base_y) in flight
		S_M1,      // dir_y * (x - base_x) in flight
		S_SIDE,    // side value ready, classify
		S_DIV,     // crossing fraction in divider
		S_IX,      // t * (cur_x - prev_x) in flight
		S_IY,      // x product ready, y product in flight
		S_PY,      // y product ready, show crossing
		S_WAIT_X,  // crossing point waiting for sink
		S_WAIT_V   // kept vertex waiting for sink
	} state_t;

	state_t state_q;

	// configuration registers
	coord_t base_x_q, base_y_q;
	dir_t   dir_x_q, dir_y_q;

	// per-polygon history
	coord_t prev_x_q, prev_y_q;
	side_t  prev_side_q;

	// current vertex
	coord_t cur_x_q, cur_y_q;
	diff_t  ex_q, ey_q;
	logic   prime_q;
	side_t  side_q;
	side_t  acc_q;
	logic   cur_in_q;
	logic   sat_q;
	frac_t  t_q;

	// output register
	logic   out_valid_q;
	coord_t out_x_q, out_y_q;
	logic   out_cross_q, out_last_q;

	// shared multiplier
	mula_t  mul_a;
	diff_t  mul_b;
	side_t  mul_p;

	// divider
	logic        div_start;
	mag_t        div_num;
	den_t        div_den;
	frac_t       div_quo;
	div_status_t div_st;

	// side value classification
	side_t  side_w;
	logic   cur_in_w;
	logic   prev_in_w;
	logic   accept;
	logic   out_take;

	// assertion helpers
	logic   waiting_w;
	logic   kept_last_w;

	assign accept   = vertex_valid && !vertex_stall;
	assign out_take = out_valid_q && !point_stall;

	assign side_w    = acc_q - mul_p;
	assign cur_in_w  = !side_w[SIDE_W-1];
	assign prev_in_w = !prev_side_q[SIDE_W-1];

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M0: begin
				mul_a = mula_t'(dir_x_q);
				mul_b = ey_q;
			end
			S_M1: begin
				mul_a = mula_t'(dir_y_q);
				mul_b = ex_q;
			end
			S_IX: begin
				mul_a = mula_t'({1'b0, t_q});
				mul_b = sx_diff(cur_x_q, prev_x_q);
			end
			S_IY: begin
				mul_a = mula_t'({1'b0, t_q});
				mul_b = sx_diff(cur_y_q, prev_y_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider launched from the classify step; den >= 1 on any crossing
	assign div_start = (state_q == S_SIDE) && !prime_q && (cur_in_w != prev_in_w);
	assign div_num   = abs_side(prev_side_q);
	assign div_den   = den_t'(abs_side(prev_side_q)) + den_t'(abs_side(side_w));

	phc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	phc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.status (div_st)
	);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
			dir_x_q  <= '0;
			dir_y_q  <= '0;
		end else if (cfg_write_en) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_X: base_x_q <= coord_t'(cfg_data);
				REG_BASE_Y: base_y_q <= coord_t'(cfg_data);
				REG_DIR_X:  dir_x_q  <= dir_t'(cfg_data[DIR_W-1:0]);
				REG_DIR_Y:  dir_y_q  <= dir_t'(cfg_data[DIR_W-1:0]);
				default: ;
			endcase
		end
	end

	// sequencer, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_side_q <= '0;
			out_valid_q <= 1'b0;
			out_cross_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_SIDE;
				S_SIDE: begin
					if (prime_q) begin
						prev_x_q    <= cur_x_q;
						prev_y_q    <= cur_y_q;
						prev_side_q <= side_w;
						state_q     <= S_IDLE;
					end else if (cur_in_w != prev_in_w) begin
						state_q <= S_DIV;
					end else begin
						prev_x_q    <= cur_x_q;
						prev_y_q    <= cur_y_q;
						prev_side_q <= side_w;
						if (cur_in_w) begin
							out_valid_q <= 1'b1;
							out_cross_q <= 1'b0;
							out_last_q  <= 1'b1;
							state_q     <= S_WAIT_V;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_IX;
					end
				end
				S_IX: state_q <= S_IY;
				S_IY: state_q <= S_PY;
				S_PY: begin
					// crossing done: history moves on to this vertex
					prev_x_q    <= cur_x_q;
					prev_y_q    <= cur_y_q;
					prev_side_q <= side_q;
					out_valid_q <= 1'b1;
					out_cross_q <= 1'b1;
					out_last_q  <= !cur_in_q;
					state_q     <= S_WAIT_X;
				end
				S_WAIT_X: begin
					if (out_take) begin
						if (cur_in_q) begin
							out_cross_q <= 1'b0;
							out_last_q  <= 1'b1;
							state_q     <= S_WAIT_V;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				S_WAIT_V: begin
					if (out_take) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= vertex_x;
			cur_y_q <= vertex_y;
			prime_q <= prime;
			ex_q    <= sx_diff(vertex_x, base_x_q);
			ey_q    <= sx_diff(vertex_y, base_y_q);
		end
		if (state_q == S_M1) begin
			acc_q <= mul_p;
		end
		if (state_q == S_SIDE) begin
			side_q   <= side_w;
			cur_in_q <= cur_in_w;
			sat_q    <= (side_w == '0);
			if (cur_in_w && (cur_in_w == prev_in_w)) begin
				out_x_q <= cur_x_q;
				out_y_q <= cur_y_q;
			end
		end
		if (state_q == S_DIV && div_st.done) begin
			// vertex on the line after an outside one: fraction would be 1.0
			t_q <= sat_q ? FRAC_MAX : div_quo;
		end
		// floor shift by the fraction bits, then wrap to 24 bits
		if (state_q == S_IY) begin
			out_x_q <= prev_x_q + mul_p[FRAC_W+COORD_W-1:FRAC_W];
		end
		if (state_q == S_PY) begin
			out_y_q <= prev_y_q + mul_p[FRAC_W+COORD_W-1:FRAC_W];
		end
		if (state_q == S_WAIT_X && out_take && cur_in_q) begin
			out_x_q <= cur_x_q;
			out_y_q <= cur_y_q;
		end
	end

	assign vertex_stall = (state_q != S_IDLE);
	assign point_valid  = out_valid_q;
	assign point_x      = out_x_q;
	assign point_y      = out_y_q;
	assign is_crossing  = out_cross_q;
	assign last_of_run  = out_last_q;

	assign waiting_w   = (state_q == S_WAIT_X) || (state_q == S_WAIT_V);
	assign kept_last_w = !is_crossing && last_of_run;

	`PHC_ASSERT(a_valid_only_waiting, point_valid |-> waiting_w, "output valid while not waiting")
	`PHC_ASSERT(a_run_continues, (out_take && !last_of_run) |=> point_valid, "run ended early")
	`PHC_ASSERT(a_vertex_closes_run, (state_q == S_WAIT_V) |-> kept_last_w, "kept vertex not last")

endmodule

>>> hdl/phc_mul.sv
// Shared signed multiplier with registered product
module phc_mul (
	input  logic           clk,
	input  phc_pkg::mula_t a,
	input  phc_pkg::diff_t b,
	output phc_pkg::side_t p
);
	import phc_pkg::*;

	side_t p_q;

	always_ff @(posedge clk) begin
		p_q <= side_t'(a) * side_t'(b);
	end

	assign p = p_q;

endmodule

>>> hdl/phc_div.sv
// Restoring divider, one quotient bit per cycle, fraction num/den
`include "assert_macros.svh"
module phc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  phc_pkg::mag_t       num,
	input  phc_pkg::den_t       den,
	output phc_pkg::frac_t      quo,
	output phc_pkg::div_status_t status
);
	import phc_pkg::*;

	localparam int CNT_W = $clog2(FRAC_W);

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem2;
	den_t             den_q;
	frac_t            quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign rem2 = {rem_q[REM_W-2:0], 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(FRAC_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REM_W'(num);
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (rem2 - REM_W'(den_q)) : rem2;
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign quo         = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	`PHC_NEVER(a_start_while_busy, start && busy_q, "divider restarted mid-division")
	`PHC_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a division")

endmodule
